/* src/spq_pkg.sv */
// Package with the sizes, codes and shared type of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [VAL_W-1:0] value;
    } spq_ctrl_t;

endpackage

`default_nettype wire

/* src/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts it with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire                       aclk,
    input  spq_pkg::spq_ctrl_t        ctrl,
    input  wire                       occupied,
    input  wire                       left_keep,
    input  wire [spq_pkg::VAL_W-1:0]  left_entry,
    input  wire [spq_pkg::VAL_W-1:0]  right_entry,
    output logic [spq_pkg::VAL_W-1:0] entry,
    output logic                      keep
);

    logic [spq_pkg::VAL_W-1:0] entry_reg;
    logic [spq_pkg::VAL_W-1:0] entry_next;

    // An entry equal to the new value stays ahead of it, so equal values leave oldest first.
    assign keep  = occupied && (entry_reg >= ctrl.value);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                entry_next = left_keep ? ctrl.value : left_entry;
            end
        end else if (ctrl.rem) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* src/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: cell chain, fill count and result register.
//
// Input beats carry one operation: s_tuser is the kind (insert or remove largest)
// and s_tdata the value to insert. Every accepted beat gives exactly one result
// beat on the master side: m_tdata holds the removed value and the occupancy
// after the operation, m_tuser the valid flag of the removed value and a status
// (done, insert rejected because full, remove on empty).
// The entries sit in a row of cells in descending order, front in cell 0. All
// cells compare against the new value at once and shift together, so each operation
// is registered at acceptance and the result appears in the cycle after acceptance.
// Throughput is one beat per cycle while the receiver takes each result.
// Reset clears the fill count and the result valid flag; the cell contents are
// left as they are and are never read until written.
// When the receiver stalls, the result waits in the output register and
// s_tready falls until it is taken, so no result is lost.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // value[15:0]
    input  wire  [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // removed_value[15:0], occupancy[20:16], zero[23:21]
    output logic [2:0]  m_tuser    // removed_valid[0], status[2:1]
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic                      m_tvalid_reg;
    logic [spq_pkg::VAL_W-1:0] rvalue_reg;
    logic [spq_pkg::VAL_W-1:0] rvalue_next;
    logic                      rvalid_reg;
    logic                      rvalid_next;
    logic [spq_pkg::STAT_W-1:0] status_reg;
    logic [spq_pkg::STAT_W-1:0] status_next;
    logic [spq_pkg::OCC_W-1:0] occ_reg;

    logic               accept;
    logic               full;
    logic               empty;
    spq_pkg::spq_ctrl_t ctrl;

    logic [spq_pkg::VAL_W-1:0] cell_entry [N];
    logic                      cell_keep  [N];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == spq_pkg::CNT_W'(N));
    assign empty    = (count_reg == '0);

    assign ctrl.ins   = accept && (s_tuser[0] == spq_pkg::KIND_INSERT) && !full;
    assign ctrl.rem   = accept && (s_tuser[0] == spq_pkg::KIND_REMOVE) && !empty;
    assign ctrl.value = s_tdata;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            logic                      occupied;
            logic                      left_keep;
            logic [spq_pkg::VAL_W-1:0] left_entry;
            logic [spq_pkg::VAL_W-1:0] right_entry;

            assign occupied = (spq_pkg::CNT_W'(i) < count_reg);

            if (i == 0) begin : g_front
                assign left_keep  = 1'b1;
                assign left_entry = '0;
            end else begin : g_mid
                assign left_keep  = cell_keep[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == N - 1) begin : g_back
                assign right_entry = '0;
            end else begin : g_notback
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occupied),
                .left_keep   (left_keep),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        rvalue_next = '0;
        rvalid_next = 1'b0;
        status_next = spq_pkg::ST_DONE;
        if (s_tuser[0] == spq_pkg::KIND_INSERT) begin
            if (full) begin
                status_next = spq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = spq_pkg::ST_EMPTY;
            end else begin
                count_next  = count_reg - 1'b1;
                rvalue_next = cell_entry[0];
                rvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rvalue_reg <= rvalue_next;
            rvalid_reg <= rvalid_next;
            status_reg <= status_next;
            occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, occ_reg, rvalue_reg};
    assign m_tuser  = {status_reg, rvalid_reg};

endmodule

`default_nettype wire
